// File: rtl/bma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bma_pkg;

  // Pool geometry defaults
  localparam int unsigned PoolBytes     = 65536;
  localparam int unsigned MinBlockBytes = 64;
  localparam int unsigned HeaderBytes   = 16;

  // Tree node codes
  localparam logic [1:0] ND_UNUSED = 2'd0;
  localparam logic [1:0] ND_FREE   = 2'd1;
  localparam logic [1:0] ND_ALLOC  = 2'd2;
  localparam logic [1:0] ND_SPLIT  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLR,
    DP_LOAD,
    DP_SRCH_INIT,
    DP_READ,
    DP_SRCH_NEXT,
    DP_SPLIT_W1,
    DP_SPLIT_W2,
    DP_ALLOC_W,
    DP_FREE_INIT,
    DP_FREE_DESC,
    DP_FREE_W,
    DP_MRG_RD,
    DP_MRG_W1,
    DP_MRG_W2,
    DP_MRG_W3
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       result;      // latch result payload
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free_op;
    logic too_large;
    logic bad_addr;
    logic node_free;
    logic node_split;
    logic node_alloc;
    logic idx_last;
    logic lvl_zero;
    logic at_target;
    logic lvl_leaf;
    logic start_match;
    logic at_root;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/bma_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bma_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/bma_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bma_datapath #(
  parameter int unsigned POOL_BYTES      = bma_pkg::PoolBytes,
  parameter int unsigned MIN_BLOCK_BYTES = bma_pkg::MinBlockBytes,
  parameter int unsigned HEADER_BYTES    = bma_pkg::HeaderBytes
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_op_i,
  input  wire logic [16:0]       in_req_i,
  input  wire logic [15:0]       in_addr_i,
  input  wire bma_pkg::dp_cmd_t  cmd_i,
  output bma_pkg::dp_stat_t      stat_o,
  output logic      [1:0]        res_status_o,
  output logic      [15:0]       res_addr_o,
  output logic      [16:0]       res_bytes_o
);

  localparam int unsigned LeafCount = POOL_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned NodeCount = 2 * LeafCount;
  localparam int unsigned Lvls      = $clog2(LeafCount);
  localparam int unsigned NodeW     = $clog2(NodeCount);
  localparam int unsigned LvlW      = $clog2(Lvls + 2);
  localparam int unsigned PoolLg    = $clog2(POOL_BYTES);
  localparam int unsigned NeedW     = (PoolLg + 1 > 18) ? PoolLg + 1 : 18;
  localparam int unsigned OffW      = (PoolLg + 1 > 18) ? PoolLg + 1 : 18;

  // Request registers
  logic              op_q;
  logic [16:0]       req_q;
  logic [15:0]       faddr_q;
  // Walk registers
  logic [LvlW-1:0]   lvl_q, tgt_q;
  logic [NodeW-1:0]  idx_q, clr_cnt_q;
  logic [PoolLg-1:0] start_q;
  logic [PoolLg:0]   fbytes_q;
  // Result registers
  logic [1:0]        res_status_q;
  logic [15:0]       res_addr_q;
  logic [16:0]       res_bytes_q;

  // Node memory
  logic             we;
  logic [NodeW-1:0] waddr, raddr;
  logic [1:0]       wdata, rdata;

  bma_ram #(.WIDTH(2), .DEPTH(NodeCount)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Allocation size and target level
  logic [NeedW-1:0] need_c;
  logic [LvlW-1:0]  tgt_c;
  always_comb begin
    need_c = NeedW'(req_q) + NeedW'(HEADER_BYTES);
    tgt_c  = '0;
    for (int l = 0; l <= int'(Lvls); l++) begin
      if (NeedW'(POOL_BYTES >> l) >= need_c) begin
        tgt_c = LvlW'(l);
      end
    end
  end

  // Free address decode
  logic [OffW-1:0]   off_c;
  logic [PoolLg-1:0] off_p;
  logic [PoolLg-1:0] off_sh;
  assign off_c  = OffW'(faddr_q) - OffW'(HEADER_BYTES);
  assign off_p  = off_c[PoolLg-1:0];
  assign off_sh = off_p >> (PoolLg - 1 - 32'(lvl_q));

  // Block size at the current level and one below
  logic [PoolLg:0] size_c, half_c;
  assign size_c = (PoolLg + 1)'(POOL_BYTES) >> lvl_q;
  assign half_c = size_c >> 1;

  // Allocated block offset
  logic [NodeW-1:0]  local_c;
  logic [PoolLg-1:0] aoff_c;
  logic [31:0]       gaddr_c;
  logic [31:0]       gbytes_c;
  assign local_c  = idx_q ^ (NodeW'(1) << lvl_q);
  assign aoff_c   = PoolLg'(local_c) << (PoolLg - 32'(lvl_q));
  assign gaddr_c  = 32'(aoff_c) + 32'(HEADER_BYTES);
  assign gbytes_c = 32'(size_c);

  // Memory port steering
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = bma_pkg::ND_UNUSED;
    raddr = idx_q;
    unique case (cmd_i.op)
      bma_pkg::DP_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt_q;
        wdata = (clr_cnt_q == NodeW'(1)) ? bma_pkg::ND_FREE : bma_pkg::ND_UNUSED;
      end
      bma_pkg::DP_SPLIT_W1: begin
        we    = 1'b1;
        wdata = bma_pkg::ND_SPLIT;
      end
      bma_pkg::DP_SPLIT_W2: begin
        we    = 1'b1;
        waddr = (idx_q << 1) | NodeW'(1);
        wdata = bma_pkg::ND_FREE;
      end
      bma_pkg::DP_ALLOC_W: begin
        we    = 1'b1;
        wdata = bma_pkg::ND_ALLOC;
      end
      bma_pkg::DP_FREE_W: begin
        we    = 1'b1;
        wdata = bma_pkg::ND_FREE;
      end
      bma_pkg::DP_MRG_RD: begin
        raddr = idx_q ^ NodeW'(1);
      end
      bma_pkg::DP_MRG_W1: begin
        we    = 1'b1;
      end
      bma_pkg::DP_MRG_W2: begin
        we    = 1'b1;
        waddr = idx_q ^ NodeW'(1);
      end
      bma_pkg::DP_MRG_W3: begin
        we    = 1'b1;
        waddr = idx_q >> 1;
        wdata = bma_pkg::ND_FREE;
      end
      default: ;
    endcase
  end

  // Clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.op == bma_pkg::DP_CLR) begin
      clr_cnt_q <= clr_cnt_q + NodeW'(1);
    end
  end

  // Walk and request registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bma_pkg::DP_LOAD: begin
        op_q    <= in_op_i;
        req_q   <= in_req_i;
        faddr_q <= in_addr_i;
      end
      bma_pkg::DP_SRCH_INIT: begin
        lvl_q <= tgt_c;
        tgt_q <= tgt_c;
        idx_q <= NodeW'(1) << tgt_c;
      end
      bma_pkg::DP_SRCH_NEXT: begin
        if (stat_o.idx_last) begin
          lvl_q <= lvl_q - LvlW'(1);
          idx_q <= NodeW'(1) << (lvl_q - LvlW'(1));
        end else begin
          idx_q <= idx_q + NodeW'(1);
        end
      end
      bma_pkg::DP_SPLIT_W2: begin
        idx_q <= idx_q << 1;
        lvl_q <= lvl_q + LvlW'(1);
      end
      bma_pkg::DP_FREE_INIT: begin
        idx_q   <= NodeW'(1);
        lvl_q   <= '0;
        start_q <= '0;
      end
      bma_pkg::DP_FREE_DESC: begin
        lvl_q <= lvl_q + LvlW'(1);
        if (off_sh[0]) begin
          start_q <= start_q + half_c[PoolLg-1:0];
          idx_q   <= (idx_q << 1) | NodeW'(1);
        end else begin
          idx_q   <= idx_q << 1;
        end
      end
      bma_pkg::DP_FREE_W: begin
        fbytes_q <= size_c;
      end
      bma_pkg::DP_MRG_W3: begin
        idx_q <= idx_q >> 1;
        lvl_q <= lvl_q - LvlW'(1);
      end
      default: ;
    endcase
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      res_status_q <= cmd_i.res_status;
      if (cmd_i.res_status != bma_pkg::ST_OK) begin
        res_addr_q  <= '0;
        res_bytes_q <= '0;
      end else if (!op_q) begin
        res_addr_q  <= gaddr_c[15:0];
        res_bytes_q <= gbytes_c[16:0];
      end else begin
        res_addr_q  <= '0;
        res_bytes_q <= 17'(32'(fbytes_q));
      end
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.clr_done    = (clr_cnt_q == NodeW'(NodeCount - 1));
    stat_o.is_free_op  = op_q;
    stat_o.too_large   = (need_c > NeedW'(POOL_BYTES));
    stat_o.bad_addr    = (faddr_q < 16'(HEADER_BYTES)) || (off_c >= OffW'(POOL_BYTES));
    stat_o.node_free   = (rdata == bma_pkg::ND_FREE);
    stat_o.node_split  = (rdata == bma_pkg::ND_SPLIT);
    stat_o.node_alloc  = (rdata == bma_pkg::ND_ALLOC);
    stat_o.idx_last    = (idx_q == ((NodeW'(2) << lvl_q) - NodeW'(1)));
    stat_o.lvl_zero    = (lvl_q == '0);
    stat_o.at_target   = (lvl_q == tgt_q);
    stat_o.lvl_leaf    = (lvl_q == LvlW'(Lvls));
    stat_o.start_match = (start_q == off_p);
    stat_o.at_root     = (idx_q == NodeW'(1));
  end

  assign res_status_o = res_status_q;
  assign res_addr_o   = res_addr_q;
  assign res_bytes_o  = res_bytes_q;

endmodule
`default_nettype wire

// File: rtl/bma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bma_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bma_pkg::dp_cmd_t       cmd_o,
  input  wire bma_pkg::dp_stat_t stat_i
);

  typedef enum logic [14:0] {
    S_CLR   = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_DEC   = 15'b000000000000100,
    S_S_RD  = 15'b000000000001000,
    S_S_CHK = 15'b000000000010000,
    S_SPL   = 15'b000000000100000,
    S_SPL2  = 15'b000000001000000,
    S_F_RD  = 15'b000000010000000,
    S_F_CHK = 15'b000000100000000,
    S_M_RD  = 15'b000001000000000,
    S_M_CHK = 15'b000010000000000,
    S_M_W1  = 15'b000100000000000,
    S_M_W2  = 15'b001000000000000,
    S_M_W3  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] status_q, status_d;
  logic       out_valid_q, out_valid_d;

  // Sequencer
  always_comb begin
    state_d        = state_q;
    status_d       = status_q;
    out_valid_d    = out_valid_q;
    cmd_o.op       = bma_pkg::DP_NONE;
    cmd_o.result   = 1'b0;
    cmd_o.res_status = status_q;
    in_ready_o     = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = bma_pkg::DP_CLR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = bma_pkg::DP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        if (stat_i.is_free_op) begin
          if (stat_i.bad_addr) begin
            status_d = bma_pkg::ST_BAD_FREE;
            state_d  = S_DONE;
          end else begin
            cmd_o.op = bma_pkg::DP_FREE_INIT;
            state_d  = S_F_RD;
          end
        end else if (stat_i.too_large) begin
          status_d = bma_pkg::ST_TOO_LARGE;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = bma_pkg::DP_SRCH_INIT;
          state_d  = S_S_RD;
        end
      end
      S_S_RD: begin
        cmd_o.op = bma_pkg::DP_READ;
        state_d  = S_S_CHK;
      end
      S_S_CHK: begin
        if (stat_i.node_free) begin
          state_d = S_SPL;
        end else if (stat_i.idx_last && stat_i.lvl_zero) begin
          status_d = bma_pkg::ST_NO_MEMORY;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = bma_pkg::DP_SRCH_NEXT;
          state_d  = S_S_RD;
        end
      end
      S_SPL: begin
        if (stat_i.at_target) begin
          cmd_o.op = bma_pkg::DP_ALLOC_W;
          status_d = bma_pkg::ST_OK;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = bma_pkg::DP_SPLIT_W1;
          state_d  = S_SPL2;
        end
      end
      S_SPL2: begin
        cmd_o.op = bma_pkg::DP_SPLIT_W2;
        state_d  = S_SPL;
      end
      S_F_RD: begin
        cmd_o.op = bma_pkg::DP_READ;
        state_d  = S_F_CHK;
      end
      S_F_CHK: begin
        if (stat_i.node_split && !stat_i.lvl_leaf) begin
          cmd_o.op = bma_pkg::DP_FREE_DESC;
          state_d  = S_F_RD;
        end else if (stat_i.node_alloc && stat_i.start_match) begin
          cmd_o.op = bma_pkg::DP_FREE_W;
          state_d  = S_M_RD;
        end else begin
          status_d = bma_pkg::ST_BAD_FREE;
          state_d  = S_DONE;
        end
      end
      S_M_RD: begin
        if (stat_i.at_root) begin
          status_d = bma_pkg::ST_OK;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = bma_pkg::DP_MRG_RD;
          state_d  = S_M_CHK;
        end
      end
      S_M_CHK: begin
        if (stat_i.node_free) begin
          state_d = S_M_W1;
        end else begin
          status_d = bma_pkg::ST_OK;
          state_d  = S_DONE;
        end
      end
      S_M_W1: begin
        cmd_o.op = bma_pkg::DP_MRG_W1;
        state_d  = S_M_W2;
      end
      S_M_W2: begin
        cmd_o.op = bma_pkg::DP_MRG_W2;
        state_d  = S_M_W3;
      end
      S_M_W3: begin
        cmd_o.op = bma_pkg::DP_MRG_W3;
        state_d  = S_M_RD;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      status_q    <= bma_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_srch_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_S_CHK) |-> $past(state_q == S_S_RD))
    else $error("search check without a read");

  a_merge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M_W3) |-> $past(state_q == S_M_W2))
    else $error("merge writes out of order");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result |=> out_valid_q)
    else $error("result latched but not presented");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_ready_o)
    else $error("input accepted during clear");

endmodule
`default_nettype wire

// File: rtl/buddy_memory_allocator.sv
// Flow: a request that is too large or a free with a bad address goes straight to the result;
//   an allocate scans nodes from the target level upward, then splits down to the target level;
//   out of memory when no free node is found; a free descends to the block, merges upward
//   while the buddy is free, or ends when the walk rejects it. Node RAM: one write port, registered read port.
// Throughput: one transaction in flight; the next is taken as soon as the FSM is idle,
//   even while the previous result waits in the output register.
// Reset: asynchronous, active low; a clearing pass rewrites all NodeCount node RAM entries
//   (2048 by default) before the first transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none
module buddy_memory_allocator #(
  parameter int unsigned POOL_BYTES      = bma_pkg::PoolBytes,
  parameter int unsigned MIN_BLOCK_BYTES = bma_pkg::MinBlockBytes,
  parameter int unsigned HEADER_BYTES    = bma_pkg::HeaderBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // request_bytes[16:0], free_address[32:17]
  input  wire logic [0:0]  s_axis_tuser,  // op[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,  // granted_address[15:0], granted_bytes[32:16]
  output logic      [1:0]  m_axis_tuser   // status[1:0]
);

  bma_pkg::dp_cmd_t  cmd;
  bma_pkg::dp_stat_t stat;
  logic [1:0]        res_status;
  logic [15:0]       res_addr;
  logic [16:0]       res_bytes;

  bma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  bma_datapath #(
    .POOL_BYTES     (POOL_BYTES),
    .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_op_i     (s_axis_tuser[0]),
    .in_req_i    (s_axis_tdata[16:0]),
    .in_addr_i   (s_axis_tdata[32:17]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_status_o(res_status),
    .res_addr_o  (res_addr),
    .res_bytes_o (res_bytes)
  );

  assign m_axis_tdata = {7'd0, res_bytes, res_addr};
  assign m_axis_tuser = res_status;

endmodule
`default_nettype wire
